// File: hw/rtl/ctfb_pkg.sv
// shared types, codes and frame constants for the crank torque frame builder
package ctfb_pkg;

	// event word and frame byte word
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] timestamp;
	} evt_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} byte_word_t;

	// event codes
	localparam logic [1:0] OP_PULSE    = 2'd0;
	localparam logic [1:0] OP_CADENCE  = 2'd1;
	localparam logic [1:0] OP_MODE     = 2'd2;
	localparam logic [1:0] OP_OVERFLOW = 2'd3;

	// register indexes
	localparam int unsigned CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 8'd2;

	localparam logic [7:0]  CHANNEL_RESET = 8'd0;
	localparam logic [15:0] SLOPE_RESET   = 16'd305;
	localparam logic [15:0] LIMIT_RESET   = 16'd2;

	typedef struct packed {
		logic [7:0]  channel;
		logic [15:0] slope;
		logic [15:0] limit;
	} cfg_regs_t;

	// kinds of work handed from front to back
	typedef enum logic [1:0] {
		JOB_TORQUE,
		JOB_OFFSET,
		JOB_SLEEP
	} job_kind_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  channel;
		logic [7:0]  rotation;
		logic [15:0] slope;
		logic [15:0] timestamp;
		logic [15:0] ticks;
	} job_t;

	localparam int unsigned QDEPTH = 2;

	// frame bytes
	localparam logic [7:0] SYNC_BYTE    = 8'hA4;
	localparam logic [7:0] DATA_LEN     = 8'h09;
	localparam logic [7:0] DATA_MSG_ID  = 8'h4E;
	localparam logic [7:0] TORQUE_PAGE  = 8'h20;
	localparam logic [7:0] CAL_PAGE     = 8'h01;
	localparam logic [7:0] CAL_ID       = 8'h10;
	localparam logic [7:0] CAL_ONE      = 8'h01;
	localparam logic [7:0] CAL_FILL     = 8'hFF;
	localparam logic [15:0] TICK_WRAP   = 16'hFFFF;
	localparam logic [15:0] IDLE_MAX    = 16'hFFFF;
	localparam logic [7:0] ROT_MAX      = 8'hFF;

	localparam int unsigned IDX_W = 4;
	localparam logic [IDX_W-1:0] DATA_LAST_IDX  = 4'd12;
	localparam logic [IDX_W-1:0] SLEEP_LAST_IDX = 4'd9;

	// reset frame then deep-sleep frame, checksums included
	function automatic logic [7:0] sleep_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'hA4;
			4'd1: b = 8'h01;
			4'd2: b = 8'h4A;
			4'd3: b = 8'h00;
			4'd4: b = 8'hEF;
			4'd5: b = 8'hA4;
			4'd6: b = 8'h01;
			4'd7: b = 8'hC5;
			4'd8: b = 8'h00;
			4'd9: b = 8'h60;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: hw/rtl/ctfb_front.sv
// event front end: keeps counters and mode, turns events into frame jobs
module ctfb_front import ctfb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  evt_word_t evt_word,
	input  cfg_regs_t cfg,
	output logic      push,
	output job_t      push_job
);

	logic [15:0] torque_count_q;
	logic [7:0]  rotation_count_q;
	logic        offset_mode_q;
	logic [15:0] idle_ticks_q;
	logic        asleep_q;

	logic [15:0] ticks_inc;
	logic [7:0]  rot_next;
	logic [15:0] idle_next;
	logic        idle_hit;
	logic        live;

	assign live      = accept && !asleep_q;
	assign ticks_inc = (torque_count_q + 16'd1 == TICK_WRAP) ? 16'd0 : torque_count_q + 16'd1;
	assign rot_next  = ((rotation_count_q == ROT_MAX) ? 8'd0 : rotation_count_q) + 8'd1;
	assign idle_next = (idle_ticks_q == IDLE_MAX) ? idle_ticks_q : idle_ticks_q + 16'd1;
	assign idle_hit  = idle_next >= cfg.limit;

	always_comb begin
		push               = 1'b0;
		push_job.kind      = offset_mode_q ? JOB_OFFSET : JOB_TORQUE;
		push_job.channel   = cfg.channel;
		push_job.rotation  = rot_next;
		push_job.slope     = cfg.slope;
		push_job.timestamp = evt_word.timestamp;
		push_job.ticks     = torque_count_q;
		if (live) begin
			case (evt_word.op)
				OP_CADENCE: push = 1'b1;
				OP_OVERFLOW: begin
					push          = idle_hit;
					push_job.kind = JOB_SLEEP;
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			torque_count_q   <= '0;
			rotation_count_q <= '0;
			offset_mode_q    <= 1'b0;
			idle_ticks_q     <= '0;
			asleep_q         <= 1'b0;
		end else if (live) begin
			case (evt_word.op)
				OP_PULSE: begin
					torque_count_q <= ticks_inc;
					idle_ticks_q   <= '0;
				end
				OP_CADENCE: begin
					rotation_count_q <= rot_next;
					if (offset_mode_q) begin
						torque_count_q <= '0;
					end
				end
				OP_MODE: offset_mode_q <= !offset_mode_q;
				OP_OVERFLOW: begin
					if (idle_hit) begin
						idle_ticks_q <= '0;
						asleep_q     <= 1'b1;
					end else begin
						idle_ticks_q <= idle_next;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hw/rtl/ctfb_queue.sv
// short job queue between front end and serializer
module ctfb_queue import ctfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic full,
	output logic empty
);

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	job_t             slot_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = count_q == CNT_W'(QDEPTH);
	assign empty   = count_q == '0;
	assign pop_job = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: hw/rtl/ctfb_back.sv
// serializer: walks a job out one frame byte per cycle while byte_stall is low, with running checksum
module ctfb_back import ctfb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       empty,
	input  job_t       pop_job,
	output logic       pop,
	output logic       byte_valid,
	input  logic       byte_stall,
	output byte_word_t byte_word
);

	job_t             job_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic             out_valid_q;
	byte_word_t       out_word_q;

	logic             advance;
	logic             emit;
	logic             last;
	logic [7:0]       cur_byte;
	logic             offset;

	assign advance = !out_valid_q || !byte_stall;
	assign emit    = busy_q && advance;
	assign last    = (job_q.kind == JOB_SLEEP) ? (idx_q == SLEEP_LAST_IDX)
	                                           : (idx_q == DATA_LAST_IDX);
	assign pop     = !empty && (!busy_q || (emit && last));
	assign offset  = job_q.kind == JOB_OFFSET;

	always_comb begin
		if (job_q.kind == JOB_SLEEP) begin
			cur_byte = sleep_byte(idx_q);
		end else begin
			case (idx_q)
				4'd0:  cur_byte = SYNC_BYTE;
				4'd1:  cur_byte = DATA_LEN;
				4'd2:  cur_byte = DATA_MSG_ID;
				4'd3:  cur_byte = job_q.channel;
				4'd4:  cur_byte = offset ? CAL_PAGE : TORQUE_PAGE;
				4'd5:  cur_byte = offset ? CAL_ID   : job_q.rotation;
				4'd6:  cur_byte = offset ? CAL_ONE  : job_q.slope[15:8];
				4'd7:  cur_byte = offset ? CAL_FILL : job_q.slope[7:0];
				4'd8:  cur_byte = offset ? CAL_FILL : job_q.timestamp[15:8];
				4'd9:  cur_byte = offset ? CAL_FILL : job_q.timestamp[7:0];
				4'd10: cur_byte = job_q.ticks[15:8];
				4'd11: cur_byte = job_q.ticks[7:0];
				4'd12: cur_byte = sum_q;
				default: cur_byte = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				idx_q <= idx_q + IDX_W'(1);
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (emit) begin
			out_word_q.frame_byte <= cur_byte;
			out_word_q.last_byte  <= last;
			sum_q                 <= ((idx_q == '0) ? 8'h00 : sum_q) ^ cur_byte;
		end
	end

	assign byte_valid = out_valid_q;
	assign byte_word  = out_word_q;

endmodule

// File: hw/rtl/crank_torque_frame_builder_core.sv
// top level of the crank torque frame builder: registers, front, queue, serializer
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+--------------------------------------
//  evt      | evt_valid / evt_stall       | evt_word: op, timestamp
//  byte     | byte_valid / byte_stall     | byte_word: frame_byte, last_byte
//  cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data (write only)
//
//  events that emit nothing are taken back to back while evt_stall is low
//  a cadence event yields 13 bytes, one per cycle from the output register while byte_stall is low;
//  the serializer loads the next job on the cycle of a job's last byte,
//  so back-to-back frames follow with no gap; the sleep run yields 10 bytes
//  evt_stall rises only while the two-entry job queue is full
//  reset is asynchronous, active low; no clearing pass is needed
module crank_torque_frame_builder_core import ctfb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 evt_valid,
	output logic                 evt_stall,
	input  evt_word_t            evt_word,
	output logic                 byte_valid,
	input  logic                 byte_stall,
	output byte_word_t           byte_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_regs_t cfg_q;
	logic      q_full;
	logic      q_empty;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      pop_job;
	logic      evt_accept;

	// config writes are always taken
	assign cfg_ready  = 1'b1;
	assign evt_stall  = q_full;
	assign evt_accept = evt_valid && !evt_stall;

	// register file, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel <= CHANNEL_RESET;
			cfg_q.slope   <= SLOPE_RESET;
			cfg_q.limit   <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CHANNEL: cfg_q.channel <= cfg_data[7:0];
				REG_SLOPE:   cfg_q.slope   <= cfg_data;
				REG_LIMIT:   cfg_q.limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front end owns all event state and decides which frames go out
	ctfb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (evt_accept),
		.evt_word (evt_word),
		.cfg      (cfg_q),
		.push     (push),
		.push_job (push_job)
	);

	// decouples event intake from byte output
	ctfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// one byte per cycle into the output register while byte_stall is low
	ctfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (q_empty),
		.pop_job    (pop_job),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word)
	);

endmodule

// File: hw/rtl/ctfb_checker.sv
// port-level checks for the frame builder, bound to the top level
module ctfb_checker import ctfb_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input byte_word_t byte_word
);

	logic [IDX_W-1:0] pos_q;
	logic             take;

	assign take = byte_valid && !byte_stall;

	// position of the next word within the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= byte_word.last_byte ? '0 : pos_q + IDX_W'(1);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_word))
		else $error("stalled byte word changed");

	a_sync: assert property (@(posedge clk) disable iff (!arst_n)
		take && pos_q == '0 |-> byte_word.frame_byte == SYNC_BYTE)
		else $error("run does not open with sync");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		take && pos_q == IDX_W'(1) |->
			byte_word.frame_byte == DATA_LEN || byte_word.frame_byte == 8'h01)
		else $error("bad length byte");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && byte_word.last_byte |-> pos_q == SLEEP_LAST_IDX || pos_q == DATA_LAST_IDX)
		else $error("run ends at wrong length");

endmodule

bind crank_torque_frame_builder_core ctfb_checker u_ctfb_checker (.*);
